/* rtl/rotenc_pkg.sv */
// rotenc_pkg: shared types and constants for the rotary encoder decoder
// no dependencies; used by the channel interfaces and the core
`default_nettype none

package rotenc_pkg;

  localparam int unsigned DivideWidth = 8;

  typedef logic [1:0]             enc_val_t;
  typedef logic [DivideWidth-1:0] divide_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_CW   = 2'd1,
    STEP_CCW  = 2'd2
  } step_e;

  // phase of the two-transition toggle
  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_FIRST  = 2'd1;
  localparam logic [1:0] PHASE_SECOND = 2'd2;

  // xor patterns of a single-pin change
  localparam enc_val_t DIFF_CW  = 2'b10;
  localparam enc_val_t DIFF_CCW = 2'b01;

endpackage

`default_nettype wire

/* rtl/rotenc_if.sv */
// rotenc channel interfaces: sample requests, step results and config writes
// depends on rotenc_pkg
`default_nettype none

interface rotenc_in_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  logic event_pending;

  modport source (output valid, output pin_a, output pin_b, output event_pending,
                  input ready);
  modport sink   (input valid, input pin_a, input pin_b, input event_pending,
                  output ready);
endinterface

interface rotenc_out_if;
  logic             valid;
  logic             ready;
  rotenc_pkg::step_e step_event;

  modport source (output valid, output step_event, input ready);
  modport sink   (input valid, input step_event, output ready);
endinterface

interface rotenc_cfg_if;
  logic                valid;
  logic                ready;
  rotenc_pkg::divide_t step_divide;

  modport source (output valid, output step_divide, input ready);
  modport sink   (input valid, input step_divide, output ready);
endinterface

`default_nettype wire

/* rtl/rotary_encoder_debounce_decoder_core.sv */
// rotary encoder debounce and direction decoder, top level
// depends on rotenc_pkg and the channel interfaces in rotenc_if.sv
//
// Each request is one timer tick carrying both encoder pins and an event
// pending flag, and each gives exactly one result: none, clockwise or
// counter-clockwise. A tick is ignored while an event is pending; otherwise
// the pin value must hold for three ticks before a change against the last
// accepted value is classified, only every second transition counts, and
// step_divide counted steps are swallowed before one is reported. A request
// goes through an input register, then the decision logic updates the
// decoder state as the tick moves into the result register: one request
// per cycle sustained, limited only by output back-pressure. step_divide is
// written through the config channel and should only change while no
// request is in flight.
`default_nettype none

module rotary_encoder_debounce_decoder_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rotenc_in_if.sink    in_ch,
  rotenc_out_if.source out_ch,
  rotenc_cfg_if.sink   cfg_ch
);
  import rotenc_pkg::*;

  // config register
  divide_t step_divide_q;

  // input stage
  logic     in_valid_q;
  enc_val_t sample_q;
  logic     pending_q;

  // decoder state
  enc_val_t   stable_value_q, stable_value_d;
  enc_val_t   last_value_q, last_value_d;
  logic [1:0] stable_count_q, stable_count_d;
  logic [1:0] phase_q, phase_d;
  divide_t    divide_count_q, divide_count_d;

  // result stage
  logic  out_valid_q;
  step_e out_event_q;
  step_e event_d;

  logic     advance;
  enc_val_t diff;
  logic [1:0] phase_next;
  logic     drop;

  assign advance      = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready  = !in_valid_q || advance;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid      = out_valid_q;
  assign out_ch.step_event = out_event_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_divide_q <= '0;
    end else if (cfg_ch.valid) begin
      step_divide_q <= cfg_ch.step_divide;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_q  <= {in_ch.pin_b, in_ch.pin_a};
      pending_q <= in_ch.event_pending;
    end
  end

  assign diff = stable_value_q ^ last_value_q;

  always_comb begin
    stable_value_d = stable_value_q;
    last_value_d   = last_value_q;
    stable_count_d = stable_count_q;
    phase_d        = phase_q;
    divide_count_d = divide_count_q;
    event_d        = STEP_NONE;
    phase_next     = phase_q;
    drop           = 1'b0;

    if (!pending_q) begin
      if (stable_value_q != sample_q) begin
        stable_value_d = sample_q;
        stable_count_d = 2'd0;
      end else if (stable_count_q <= 2'd1) begin
        stable_count_d = stable_count_q + 2'd1;
      end else if (last_value_q != stable_value_q) begin
        if (diff == DIFF_CW || diff == DIFF_CCW) begin
          phase_next = (phase_q == PHASE_IDLE) ? PHASE_FIRST : PHASE_SECOND;
          if (phase_next == PHASE_FIRST) begin
            if (divide_count_q < step_divide_q) begin
              // swallowed: same transition is seen again on the next tick
              divide_count_d = divide_count_q + divide_t'(1);
              drop           = 1'b1;
            end else begin
              divide_count_d = '0;
              event_d        = (diff == DIFF_CW) ? STEP_CW : STEP_CCW;
            end
          end
        end
        if (drop) begin
          phase_d = phase_next;
        end else begin
          phase_d        = (phase_next == PHASE_SECOND) ? PHASE_IDLE : phase_next;
          stable_count_d = 2'd0;
          last_value_d   = stable_value_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_value_q <= '0;
      last_value_q   <= '0;
      stable_count_q <= '0;
      phase_q        <= PHASE_IDLE;
      divide_count_q <= '0;
    end else if (advance) begin
      stable_value_q <= stable_value_d;
      last_value_q   <= last_value_d;
      stable_count_q <= stable_count_d;
      phase_q        <= phase_d;
      divide_count_q <= divide_count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_event_q <= event_d;
    end
  end

endmodule

`default_nettype wire
